[rtl/core/hlpc_pkg.sv]
// Shared types and constants for the Hessian line point classifier.
// No dependencies; used by every module under rtl/core.
package hlpc_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int MAX_ROWS    = 2048;
    localparam int MAX_COLS    = 2048;
    localparam int NORMAL_BITS = 10;   // normal components kept below 2**NORMAL_BITS
    localparam int SQ_STEPS    = 25;   // root bits of a 50-bit radicand
    localparam int DIV_STEPS   = 10;   // quotient bits of the offset divide

    localparam logic [8:0]  OFFSET_LIMIT_RESET = 9'd128;
    localparam logic [23:0] STRENGTH_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic signed [23:0] grad_x;
        logic signed [23:0] grad_y;
        logic signed [23:0] hess_xx;
        logic signed [23:0] hess_xy;
        logic signed [23:0] hess_yy;
        logic        [10:0] pixel_row;
        logic        [10:0] pixel_col;
    } t_in_item;

    typedef struct packed {
        logic               line_found;
        logic        [23:0] strength;
        logic signed [19:0] sub_x;
        logic signed [19:0] sub_y;
    } t_out_item;

    // Carried alongside the square root pipeline.
    typedef struct packed {
        logic signed [24:0] d;       // hyy - hxx
        logic signed [24:0] sum;     // hxx + hyy
        logic signed [23:0] h;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic        [10:0] row;
        logic        [10:0] col;
        logic               in_frame;
    } t_sqrt_side;

    // Carried alongside the divider.
    typedef struct packed {
        logic        ok;
        logic [23:0] strength;
        logic [10:0] row;
        logic [10:0] col;
        logic        neg_x;
        logic        neg_y;
    } t_div_side;

endpackage

[rtl/core/hlpc_front.sv]
// Front stages: difference, sum and radicand D^2 + 4 hxy^2.
// Depends on hlpc_pkg.
module hlpc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hlpc_pkg::t_in_item  i_item,
    output logic                o_valid,
    output logic [49:0]         o_r2,
    output hlpc_pkg::t_sqrt_side o_side
);

    logic                 r_v1, r_v2;
    hlpc_pkg::t_sqrt_side r_side1, r_side2;
    logic [49:0]          r_r2;

    logic signed [49:0]   w_dsq;
    logic signed [47:0]   w_hsq;
    hlpc_pkg::t_sqrt_side n_side1;

    always_comb begin
        n_side1.d   = $signed({i_item.hess_yy[23], i_item.hess_yy})
                    - $signed({i_item.hess_xx[23], i_item.hess_xx});
        n_side1.sum = $signed({i_item.hess_yy[23], i_item.hess_yy})
                    + $signed({i_item.hess_xx[23], i_item.hess_xx});
        n_side1.h   = i_item.hess_xy;
        n_side1.gx  = i_item.grad_x;
        n_side1.gy  = i_item.grad_y;
        n_side1.row = i_item.pixel_row;
        n_side1.col = i_item.pixel_col;
        n_side1.in_frame = ({3'b000, i_item.pixel_row} < 14'(hlpc_pkg::MAX_ROWS))
                        && ({3'b000, i_item.pixel_col} < 14'(hlpc_pkg::MAX_COLS));
    end

    assign w_dsq = r_side1.d * r_side1.d;
    assign w_hsq = r_side1.h * r_side1.h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side1;
            r_side2 <= r_side1;
            r_r2    <= $unsigned(w_dsq) + {w_hsq, 2'b00};
        end
    end

    assign o_valid = r_v2;
    assign o_r2    = r_r2;
    assign o_side  = r_side2;

endmodule

[rtl/core/hlpc_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on hlpc_pkg.
module hlpc_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [49:0]          i_x,
    input  hlpc_pkg::t_sqrt_side i_side,
    output logic                 o_valid,
    output logic [24:0]          o_root,
    output hlpc_pkg::t_sqrt_side o_side
);

    localparam int N = hlpc_pkg::SQ_STEPS;

    logic                 r_v    [N];
    logic [49:0]          r_x    [N];
    logic [25:0]          r_rem  [N];
    logic [24:0]          r_root [N];
    hlpc_pkg::t_sqrt_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                 w_v;
        logic [49:0]          w_x;
        logic [25:0]          w_rem;
        logic [24:0]          w_root;
        hlpc_pkg::t_sqrt_side w_side;
        logic [27:0]          w_tmp, w_trial;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_x    = i_x;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_tmp   = {w_rem, w_x[49:48]};
        assign w_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= {w_x[47:0], 2'b00};
                r_side[k] <= w_side;
                if (w_tmp >= w_trial) begin
                    r_rem[k]  <= 26'(w_tmp - w_trial);
                    r_root[k] <= {w_root[23:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_tmp[25:0];
                    r_root[k] <= {w_root[23:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

[rtl/core/hlpc_normal.sv]
// Eigenvalue sign, normal vector, dot product, offset numerators and limit test.
// Depends on hlpc_pkg.
module hlpc_normal (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [8:0]           i_limit,
    input  logic                 i_valid,
    input  logic [24:0]          i_root,
    input  hlpc_pkg::t_sqrt_side i_side,
    output logic                 o_valid,
    output logic [54:0]          o_num_x,
    output logic [54:0]          o_num_y,
    output logic [47:0]          o_d2,
    output hlpc_pkg::t_div_side  o_side
);

    typedef struct packed {
        logic               line;
        logic        [25:0] s;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic        [10:0] row;
        logic        [10:0] col;
    } t_norm_side;

    logic [6:0] r_v;

    // stage 1
    t_norm_side         r1_c;
    logic signed [26:0] r1_nx, r1_ny;
    // stage 2
    t_norm_side         r2_c;
    logic [26:0]        r2_ax, r2_ay;
    logic               r2_sx, r2_sy;
    logic [4:0]         r2_sh;
    // stage 3
    t_norm_side         r3_c;
    logic [9:0]         r3_ax, r3_ay;
    logic               r3_sx, r3_sy;
    // stage 4
    t_norm_side         r4_c;
    logic signed [34:0] r4_dot;
    logic [20:0]        r4_n2;
    logic [9:0]         r4_ax, r4_ay;
    logic               r4_nxn, r4_nyn;
    // stage 5
    logic               r5_line;
    logic [46:0]        r5_den;
    logic [52:0]        r5_mx, r5_my;
    hlpc_pkg::t_div_side r5_sd;
    // stage 6
    logic               r6_line;
    logic [46:0]        r6_den;
    logic [52:0]        r6_mx, r6_my;
    logic [55:0]        r6_lim;
    hlpc_pkg::t_div_side r6_sd;
    // stage 7
    logic [54:0]        r7_nx, r7_ny;
    logic [47:0]        r7_d2;
    hlpc_pkg::t_div_side r7_sd;

    // stage 1: s = R - SUM, normal before scaling
    t_norm_side         n1_c;
    logic signed [26:0] n1_s, n1_d, n1_r, n1_h2, n1_nx, n1_ny;

    always_comb begin
        n1_d  = {{2{i_side.d[24]}}, i_side.d};
        n1_r  = {2'b00, i_root};
        n1_h2 = {{2{i_side.h[23]}}, i_side.h, 1'b0};
        n1_s  = n1_r - {{2{i_side.sum[24]}}, i_side.sum};
        if (i_side.h == '0) begin
            n1_nx = i_side.d[24] ? 27'sd0 : 27'sd1;
            n1_ny = i_side.d[24] ? 27'sd1 : 27'sd0;
        end else if (!i_side.d[24]) begin
            n1_nx = -n1_d - n1_r;
            n1_ny = n1_h2;
        end else begin
            n1_nx = n1_h2;
            n1_ny = n1_d - n1_r;
        end
        n1_c.line = i_side.in_frame && !n1_s[26] && (n1_s != '0);
        n1_c.s    = n1_s[25:0];
        n1_c.gx   = i_side.gx;
        n1_c.gy   = i_side.gy;
        n1_c.row  = i_side.row;
        n1_c.col  = i_side.col;
    end

    // stage 2: magnitudes and common scale
    logic [26:0] n2_ax, n2_ay, n2_m;
    logic [4:0]  n2_sh;

    always_comb begin
        n2_ax = r1_nx[26] ? 27'(-r1_nx) : 27'(r1_nx);
        n2_ay = r1_ny[26] ? 27'(-r1_ny) : 27'(r1_ny);
        n2_m  = n2_ax | n2_ay;
        n2_sh = '0;
        for (int i = hlpc_pkg::NORMAL_BITS; i < 27; i++) begin
            if (n2_m[i]) n2_sh = 5'(i - hlpc_pkg::NORMAL_BITS + 1);
        end
    end

    // stage 4: dot product with the gradient
    logic signed [10:0] n4_nx, n4_ny;
    logic signed [34:0] n4_px, n4_py;

    always_comb begin
        n4_nx = r3_sx ? -$signed({1'b0, r3_ax}) : $signed({1'b0, r3_ax});
        n4_ny = r3_sy ? -$signed({1'b0, r3_ay}) : $signed({1'b0, r3_ay});
        n4_px = n4_nx * r3_c.gx;
        n4_py = n4_ny * r3_c.gy;
    end

    // stage 5: denominator, numerator magnitudes, strength
    logic [33:0] n5_adot;
    logic [26:0] n5_st;
    hlpc_pkg::t_div_side n5_sd;

    always_comb begin
        n5_adot = r4_dot[34] ? 34'(-r4_dot) : 34'(r4_dot);
        n5_st   = ({1'b0, r4_c.s} + 27'd1) >> 1;
        n5_sd.ok       = 1'b0;
        n5_sd.strength = (n5_st > {3'b000, hlpc_pkg::STRENGTH_MAX})
                       ? hlpc_pkg::STRENGTH_MAX : n5_st[23:0];
        n5_sd.row   = r4_c.row;
        n5_sd.col   = r4_c.col;
        n5_sd.neg_x = r4_dot[34] ^ r4_nxn;
        n5_sd.neg_y = r4_dot[34] ^ r4_nyn;
    end

    // stage 7: limit test and rounding numerators
    hlpc_pkg::t_div_side n7_sd;

    always_comb begin
        n7_sd    = r6_sd;
        n7_sd.ok = r6_line && (r6_den != '0)
                && ({3'b000, r6_mx} <= r6_lim) && ({3'b000, r6_my} <= r6_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c  <= n1_c;
            r1_nx <= n1_nx;
            r1_ny <= n1_ny;

            r2_c  <= r1_c;
            r2_ax <= n2_ax;
            r2_ay <= n2_ay;
            r2_sx <= r1_nx[26];
            r2_sy <= r1_ny[26];
            r2_sh <= n2_sh;

            r3_c  <= r2_c;
            r3_ax <= 10'(r2_ax >> r2_sh);
            r3_ay <= 10'(r2_ay >> r2_sh);
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;

            r4_c   <= r3_c;
            r4_dot <= n4_px + n4_py;
            r4_n2  <= 21'(r3_ax * r3_ax) + 21'(r3_ay * r3_ay);
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_nxn <= r3_sx && (r3_ax != '0);
            r4_nyn <= r3_sy && (r3_ay != '0);

            r5_line <= r4_c.line;
            r5_den  <= 47'(r4_c.s * r4_n2);
            r5_mx   <= 53'(n5_adot * r4_ax) << (hlpc_pkg::FRAC_BITS + 1);
            r5_my   <= 53'(n5_adot * r4_ay) << (hlpc_pkg::FRAC_BITS + 1);
            r5_sd   <= n5_sd;

            r6_line <= r5_line;
            r6_den  <= r5_den;
            r6_mx   <= r5_mx;
            r6_my   <= r5_my;
            r6_lim  <= 56'(i_limit * r5_den);
            r6_sd   <= r5_sd;

            r7_nx <= {1'b0, r6_mx, 1'b0} + {8'd0, r6_den};
            r7_ny <= {1'b0, r6_my, 1'b0} + {8'd0, r6_den};
            r7_d2 <= {r6_den, 1'b0};
            r7_sd <= n7_sd;
        end
    end

    assign o_valid = r_v[6];
    assign o_num_x = r7_nx;
    assign o_num_y = r7_ny;
    assign o_d2    = r7_d2;
    assign o_side  = r7_sd;

endmodule

[rtl/core/hlpc_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on hlpc_pkg.
module hlpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [54:0]         i_num_x,
    input  logic [54:0]         i_num_y,
    input  logic [47:0]         i_d2,
    input  hlpc_pkg::t_div_side i_side,
    output logic                o_valid,
    output logic [9:0]          o_q_x,
    output logic [9:0]          o_q_y,
    output hlpc_pkg::t_div_side o_side
);

    localparam int N = hlpc_pkg::DIV_STEPS;

    logic                r_v    [N];
    logic [57:0]         r_rx   [N];
    logic [57:0]         r_ry   [N];
    logic [9:0]          r_qx   [N];
    logic [9:0]          r_qy   [N];
    logic [47:0]         r_d2   [N];
    hlpc_pkg::t_div_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                w_v;
        logic [57:0]         w_rx, w_ry, w_cmp;
        logic [9:0]          w_qx, w_qy;
        logic [47:0]         w_d2;
        hlpc_pkg::t_div_side w_side;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rx   = {3'b000, i_num_x};
            assign w_ry   = {3'b000, i_num_y};
            assign w_qx   = '0;
            assign w_qy   = '0;
            assign w_d2   = i_d2;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rx   = r_rx[k-1];
            assign w_ry   = r_ry[k-1];
            assign w_qx   = r_qx[k-1];
            assign w_qy   = r_qy[k-1];
            assign w_d2   = r_d2[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_cmp = {10'd0, w_d2} << (N - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d2[k]   <= w_d2;
                r_side[k] <= w_side;
                r_rx[k]   <= (w_rx >= w_cmp) ? w_rx - w_cmp : w_rx;
                r_ry[k]   <= (w_ry >= w_cmp) ? w_ry - w_cmp : w_ry;
                r_qx[k]   <= {w_qx[8:0], w_rx >= w_cmp};
                r_qy[k]   <= {w_qy[8:0], w_ry >= w_cmp};
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_q_x   = r_qx[N-1];
    assign o_q_y   = r_qy[N-1];
    assign o_side  = r_side[N-1];

endmodule

[rtl/core/hessian_line_point_classifier.sv]
// Top level of the Hessian line point classifier: config register, stall
// control, output stage. Depends on hlpc_pkg, hlpc_front, hlpc_sqrt,
// hlpc_normal, hlpc_div.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------
//  in       | input     | i_in_valid/o_in_stall  | i_in_data  (t_in_item)
//  out      | output    | o_out_valid/i_out_stall| o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (offset_limit)
//
// One transaction in and one result out per cycle unless the output stalls;
// stages: 2 front, 25 square-root steps (one root bit each), 7 normal/offset
// stages, 10 divider steps (one quotient bit each), 1 output register.
// Synchronous active-low reset clears all valid bits and sets offset_limit
// to 128. An output stall with a result waiting freezes the whole pipeline
// and stalls the input in the same cycle; nothing is dropped or duplicated.
module hessian_line_point_classifier (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hlpc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hlpc_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [8:0]           i_cfg_data
);

    logic [8:0] r_limit;
    logic       r_out_valid;
    hlpc_pkg::t_out_item r_out;

    logic w_en;

    // front -> sqrt
    logic                 w_f_valid;
    logic [49:0]          w_f_r2;
    hlpc_pkg::t_sqrt_side w_f_side;
    // sqrt -> normal
    logic                 w_s_valid;
    logic [24:0]          w_s_root;
    hlpc_pkg::t_sqrt_side w_s_side;
    // normal -> div
    logic                 w_n_valid;
    logic [54:0]          w_n_num_x, w_n_num_y;
    logic [47:0]          w_n_d2;
    hlpc_pkg::t_div_side  w_n_side;
    // div -> output
    logic                 w_d_valid;
    logic [9:0]           w_d_qx, w_d_qy;
    hlpc_pkg::t_div_side  w_d_side;

    // Whole pipe advances unless a finished result is held off.
    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hlpc_pkg::OFFSET_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    hlpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (w_f_valid),
        .o_r2    (w_f_r2),
        .o_side  (w_f_side)
    );

    hlpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_x     (w_f_r2),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    hlpc_normal u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_limit (r_limit),
        .i_valid (w_s_valid),
        .i_root  (w_s_root),
        .i_side  (w_s_side),
        .o_valid (w_n_valid),
        .o_num_x (w_n_num_x),
        .o_num_y (w_n_num_y),
        .o_d2    (w_n_d2),
        .o_side  (w_n_side)
    );

    hlpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n_valid),
        .i_num_x (w_n_num_x),
        .i_num_y (w_n_num_y),
        .i_d2    (w_n_d2),
        .i_side  (w_n_side),
        .o_valid (w_d_valid),
        .o_q_x   (w_d_qx),
        .o_q_y   (w_d_qy),
        .o_side  (w_d_side)
    );

    // Output stage: sign the rounded offsets and add the pixel position.
    logic signed [10:0]  w_px, w_py;
    hlpc_pkg::t_out_item n_out;

    always_comb begin
        w_px = w_d_side.neg_x ? -$signed({1'b0, w_d_qx}) : $signed({1'b0, w_d_qx});
        w_py = w_d_side.neg_y ? -$signed({1'b0, w_d_qy}) : $signed({1'b0, w_d_qy});
        n_out = '0;
        if (w_d_side.ok) begin
            n_out.line_found = 1'b1;
            n_out.strength   = w_d_side.strength;
            n_out.sub_x = $signed({1'b0, w_d_side.col, {hlpc_pkg::FRAC_BITS{1'b0}}})
                        + $signed({{9{w_px[10]}}, w_px});
            n_out.sub_y = $signed({1'b0, w_d_side.row, {hlpc_pkg::FRAC_BITS{1'b0}}})
                        + $signed({{9{w_py[10]}}, w_py});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A reported line point always carries a nonzero strength.
    a_strength_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_found |-> o_out_data.strength != '0)
        else $error("line point with zero strength");

    // No line point: every field is zero.
    a_no_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.line_found |->
            o_out_data.strength == '0 && o_out_data.sub_x == '0 && o_out_data.sub_y == '0)
        else $error("nonzero fields without a line point");

    // Input is held off only while a result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // Pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

[tb/hlpc_scoreboard.sv]
// Checker for the Hessian line point classifier: watches the in, out and
// cfg channels, predicts each result and compares it. Depends on hlpc_pkg.
`timescale 1ns / 100ps
module hlpc_scoreboard
    import hlpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_lines_seen
);

    logic [8:0] limit_q;
    t_out_item  expected_points[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Offset on one axis; returns 0 when beyond the limit.
    function automatic bit axis_shift(longint dot, longint ncomp, longint unsigned den,
                                      logic [8:0] lim, output longint p);
        longint unsigned mag;
        longint unsigned q;
        bit neg;
        mag = (abs64(dot) * abs64(ncomp)) << (FRAC_BITS + 1);
        neg = (dot < 0) != (ncomp < 0);
        p = 0;
        if (mag > longint'(lim) * den) return 0;
        q = (2 * mag + den) / (2 * den);
        p = neg ? -longint'(q) : longint'(q);
        return 1;
    endfunction

    function automatic t_out_item classify_pixel(t_in_item it, logic [8:0] lim);
        t_out_item res;
        longint gx, gy, a, h, b, d, sum, s, nx, ny, dot, px, py, r;
        longint unsigned ax, ay, den, str;
        res = '0;
        gx = it.grad_x;  gy = it.grad_y;
        a = it.hess_xx;  h = it.hess_xy;  b = it.hess_yy;
        if (it.pixel_row >= MAX_ROWS || it.pixel_col >= MAX_COLS) return res;
        d = b - a;
        sum = a + b;
        r = longint'(int_sqrt(longint'(d * d) + 4 * longint'(h * h)));
        s = r - sum;  // twice the negated smaller eigenvalue
        if (s < 1) return res;
        if (h == 0) begin
            nx = (a <= b) ? 1 : 0;
            ny = (a <= b) ? 0 : 1;
        end else if (d >= 0) begin
            nx = -d - r;
            ny = 2 * h;
        end else begin
            nx = 2 * h;
            ny = d - r;
        end
        ax = abs64(nx);
        ay = abs64(ny);
        while (ax >= 1024 || ay >= 1024) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        nx = (nx < 0) ? -longint'(ax) : longint'(ax);
        ny = (ny < 0) ? -longint'(ay) : longint'(ay);
        dot = nx * gx + ny * gy;
        den = longint'(s) * (ax * ax + ay * ay);
        if (den == 0) return res;
        if (!axis_shift(dot, nx, den, lim, px)) return res;
        if (!axis_shift(dot, ny, den, lim, py)) return res;
        str = (longint'(s) + 1) >> 1;
        if (str > STRENGTH_MAX) str = STRENGTH_MAX;
        res.line_found = 1'b1;
        res.strength   = str[23:0];
        res.sub_x      = 20'(longint'(it.pixel_col) * (1 << FRAC_BITS) + px);
        res.sub_y      = 20'(longint'(it.pixel_row) * (1 << FRAC_BITS) + py);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            limit_q <= OFFSET_LIMIT_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) limit_q <= i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_points.push_back(classify_pixel(i_in_data, limit_q));
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_out_data);
                end else begin
                    want = expected_points.pop_front();
                    if (want.line_found) o_lines_seen <= o_lines_seen + 1;
                    if (want.line_found !== i_out_data.line_found ||
                        want.strength !== i_out_data.strength ||
                        want.sub_x !== i_out_data.sub_x ||
                        want.sub_y !== i_out_data.sub_y) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                    end
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_lines_seen = 0;
        limit_q = OFFSET_LIMIT_RESET;
    end

    always @(posedge i_clk) o_pending <= expected_points.size();

endmodule

[tb/hessian_line_point_classifier_tb.sv]
// Testbench top for the Hessian line point classifier: clock, reset,
// stimulus and verdict. Depends on hlpc_pkg, hlpc_scoreboard and the RTL.
`timescale 1ns / 100ps
module hessian_line_point_classifier_tb;
    import hlpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;   // long output hold-off
    localparam int DRAIN_WAIT  = 50;    // settling wait after the scoreboard empties

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data = '0;

    int fail_count, pending, lines_seen;
    int pixels_sent = 0;
    int limits_used = 0;
    int cycle_count = 0;
    bit quiet = 0;        // no idling on either side
    bit hold_armed = 0;   // asks the output side for one long hold-off
    bit hold_done = 0;

    always #10 i_clk = ~i_clk;

    hessian_line_point_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    hlpc_scoreboard u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_lines_seen(lines_seen)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output side: random stall bursts, quiet stretches, and one long hold-off
    // during which the pipe fills and the input gets stalled.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_armed && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1;
            end else if (quiet) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 18);
                if ($urandom_range(0, 2) == 0) out_stall <= 1'b1;
                else begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // One pixel transaction; valid stays high into the next call when no gap.
    task automatic push_pixel(t_in_item px);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge i_clk); while (in_stall);
        pixels_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let everything drain; the sender holds off until the pipe is empty.
    task automatic drain_pipe();
        end_burst();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [8:0] lim);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limits_used++;
    endtask

    function automatic t_in_item pixel_of(int gx, int gy, int a, int h, int b,
                                          int row, int col);
        t_in_item p;
        p.grad_x = 24'(gx);  p.grad_y = 24'(gy);
        p.hess_xx = 24'(a);  p.hess_xy = 24'(h);  p.hess_yy = 24'(b);
        p.pixel_row = 11'(row);  p.pixel_col = 11'(col);
        return p;
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly line-shaped pixels: one strongly negative curvature, gradient
    // along it scaled so the offset lands near the limit; the rest is noise.
    function automatic t_in_item random_pixel();
        t_in_item p;
        int lam, g, gt, other, h;
        p = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 7) begin
            lam   = $urandom_range(16, 1 << ($urandom_range(6, 22)));
            other = rand_signed(lam / 4);
            h     = ($urandom_range(0, 3) == 0) ? 0 : rand_signed(lam / 3);
            g     = rand_signed(lam);
            gt    = rand_signed(lam * 4 > (1 << 22) ? (1 << 22) : lam * 4);
            p.hess_xy = 24'(h);
            if ($urandom_range(0, 1)) begin
                p.hess_xx = 24'(-lam);  p.hess_yy = 24'(other);
                p.grad_x  = 24'(g);     p.grad_y  = 24'(gt);
            end else begin
                p.hess_yy = 24'(-lam);  p.hess_xx = 24'(other);
                p.grad_y  = 24'(g);     p.grad_x  = 24'(gt);
            end
        end
        return p;
    endfunction

    task automatic random_phase(int count);
        repeat (count) push_pixel(random_pixel());
    endtask

    localparam int SMAX = 8388607;
    localparam int SMIN = -8388608;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at the reset limit of half a pixel.
        push_pixel(pixel_of(0, 0, 0, 0, 0, 0, 0));                      // flat
        push_pixel(pixel_of(SMAX, SMAX, SMAX, SMAX, SMAX, 2047, 2047));
        push_pixel(pixel_of(SMIN, SMIN, SMIN, SMIN, SMIN, 2047, 2047));
        push_pixel(pixel_of(0, 0, SMIN, SMIN, SMIN, 2047, 0));          // saturates
        push_pixel(pixel_of(0, 0, -4096, 0, -4096, 5, 7));             // tie, xy zero
        push_pixel(pixel_of(100, 0, -4096, 0, 10, 9, 9));               // xy zero, xx <= yy
        push_pixel(pixel_of(0, 100, 10, 0, -4096, 9, 9));               // xy zero, xx > yy
        push_pixel(pixel_of(300, -200, -5000, 700, 20, 100, 200));      // yy - xx >= 0
        push_pixel(pixel_of(-300, 200, 20, -700, -5000, 100, 200));     // yy - xx < 0
        push_pixel(pixel_of(5000, 0, -4096, 0, 0, 3, 3));               // beyond limit x
        push_pixel(pixel_of(0, -5000, 0, 0, -4096, 3, 3));              // beyond limit y
        push_pixel(pixel_of(2048, 0, -4096, 0, 0, 0, 0));               // exactly at limit
        push_pixel(pixel_of(-1000, 0, -4096, 0, 0, 0, 0));              // negative position
        push_pixel(pixel_of(1000, 1000, 4096, 0, 4096, 1, 1));          // no negative root
        push_pixel(pixel_of(SMAX, SMIN, -256, 1, -256, 1024, 1024));
        push_pixel(pixel_of(1, -1, -1, 0, 0, 2047, 2047));              // smallest curvature
        random_phase(100);
        drain_pipe();

        write_limit(9'd0);
        push_pixel(pixel_of(0, 0, -4096, 0, 0, 4, 4));                  // zero offset only
        random_phase(60);
        drain_pipe();

        // Long output hold-off while the sender keeps offering.
        write_limit(9'd256);
        hold_armed = 1;
        random_phase(120);
        drain_pipe();

        write_limit(9'd511);
        push_pixel(pixel_of(SMAX, SMAX, SMIN, 0, 0, 2047, 2047));
        random_phase(110);
        drain_pipe();

        write_limit(9'($urandom_range(2, 510)));
        random_phase(90);
        drain_pipe();

        write_limit(9'd1);
        random_phase(60);
        drain_pipe();

        // Last stretch back at the default, back to back on both sides.
        write_limit(OFFSET_LIMIT_RESET);
        quiet = 1;
        random_phase(80);
        drain_pipe();

        $display("covered %0d pixels over %0d offset limits, %0d line points found",
                 pixels_sent, limits_used, lines_seen);
        $display("long hold-off exercised: %0d", hold_done);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
